// ===== rtl/core/ljpf_pkg.sv =====
// ============================================================================
// ljpf_pkg
// Shared widths, register indexes and defaults for the LJ pair force kernel.
// ============================================================================
package ljpf_pkg;

	localparam int COORD_W             = 31;
	localparam int COORD_FRAC_BITS_DEF = 22;
	localparam int CFG_ADDR_W          = 3;
	localparam int CFG_DATA_W          = 48;
	localparam int SQ_W                = 48;
	localparam int OUT_W               = 48;
	localparam int ESCALE_W            = 32;
	localparam int INV2_W              = 41;
	localparam int DIV_STEPS           = INV2_W;
	localparam int S_TDATA_W           = 192;
	localparam int M_TDATA_W           = 200;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_BOX_SIZE       = 3'd0,
		CFG_WRAP_THRESHOLD = 3'd1,
		CFG_LIST_RADIUS_SQ = 3'd2,
		CFG_CUTOFF_SQ      = 3'd3,
		CFG_ENERGY_SCALE   = 3'd4,
		CFG_ENERGY_SHIFT   = 3'd5
	} cfg_reg_t;

endpackage

// ===== rtl/core/lj_pair_force_kernel.sv =====
// ============================================================================
// lj_pair_force_kernel
// Lennard-Jones pair force and shifted energy with one minimum-image fold.
// ============================================================================
// Takes one particle pair per clock unless the master side stalls, and
// returns one result per pair, in order. The pipeline is 64 register stages
// deep. The depth is set by the 41-stage radix-2 reciprocal (one quotient
// bit per stage) and by the wide multiplies, each split into 32-bit partial
// products over two stages. A single skid register at the input keeps the
// slave side taking one more request while a result waits on the master
// side; a stalled master holds the whole pipeline. Configuration writes
// take effect at once and belong to quiet periods only.
module lj_pair_force_kernel #(
	parameter int COORD_FRAC_BITS = ljpf_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ljpf_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ljpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z (31 b each), pad
	input  logic [ljpf_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// force_x, force_y, force_z, pair_energy (48 b each), within_list,
	// within_cutoff, pad
	output logic [ljpf_pkg::M_TDATA_W-1:0]  m_tdata
);
	import ljpf_pkg::*;

	localparam int SQ_SHIFT = 2 * COORD_FRAC_BITS - 30;

	localparam int ST_MAG   = 2;
	localparam int ST_Q     = 5;
	localparam int ST_DIV0  = 6;
	localparam int ST_INV2  = ST_DIV0 + DIV_STEPS - 1;
	localparam int ST_P4    = ST_INV2 + 1;
	localparam int ST_INV4  = ST_INV2 + 2;
	localparam int ST_G2    = ST_INV2 + 11;
	localparam int ST_DA    = ST_INV2 + 13;
	localparam int ST_F     = ST_INV2 + 15;
	localparam int ST_SAT   = ST_INV2 + 16;
	localparam int ST_OUT   = ST_INV2 + 17;

	localparam logic [SQ_W-1:0]      SQ_MAX   = {SQ_W{1'b1}};
	localparam logic [SQ_W-1:0]      SQ_FLOOR = 48'h40_0000;
	localparam logic [SQ_W-1:0]      REM_INIT = 48'h20_0000;
	localparam logic [80:0]          A12_CAP  = 81'h400_0000_0000_0000;
	localparam logic signed [60:0]   EN_MAX   = 61'sh7FFF_FFFF_FFFF;
	localparam logic signed [60:0]   EN_MIN   = -61'sh8000_0000_0000;
	localparam logic [OUT_W-1:0]     POS_LIM  = 48'h7FFF_FFFF_FFFF;
	localparam logic [OUT_W-1:0]     NEG_LIM  = 48'h8000_0000_0000;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] mag;
		logic [2:0]              neg;
		logic                    wl;
		logic                    wc;
		logic                    gneg;
		logic signed [OUT_W-1:0] energy;
	} side_t;

	function automatic logic signed [31:0] fold_fn(input logic signed [31:0] d,
			input logic [COORD_W-1:0] t, input logic [COORD_W-1:0] s);
		logic signed [33:0] d34, t34, s34, r;
		d34 = 34'(d);
		t34 = $signed({3'b0, t});
		s34 = $signed({3'b0, s});
		if (d34 > t34) begin
			r = d34 - s34;
		end else if (d34 < -t34) begin
			r = d34 + s34;
		end else begin
			r = d34;
		end
		return r[31:0];
	endfunction

	// configuration
	logic [COORD_W-1:0]      box_q, wrap_q;
	logic [SQ_W-1:0]         lrad_q, cut_q;
	logic [ESCALE_W-1:0]     escale_q;
	logic signed [OUT_W-1:0] eshift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q    <= '0;
			wrap_q   <= '0;
			lrad_q   <= '0;
			cut_q    <= '0;
			escale_q <= '0;
			eshift_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_BOX_SIZE:       box_q    <= cfg_wdata[COORD_W-1:0];
				CFG_WRAP_THRESHOLD: wrap_q   <= cfg_wdata[COORD_W-1:0];
				CFG_LIST_RADIUS_SQ: lrad_q   <= cfg_wdata[SQ_W-1:0];
				CFG_CUTOFF_SQ:      cut_q    <= cfg_wdata[SQ_W-1:0];
				CFG_ENERGY_SCALE:   escale_q <= cfg_wdata[ESCALE_W-1:0];
				CFG_ENERGY_SHIFT:   eshift_q <= $signed(cfg_wdata[OUT_W-1:0]);
				default: ;
			endcase
		end
	end

	// input skid and pipeline control
	logic                 en, acc, in_v, skid_v_q;
	logic [S_TDATA_W-1:0] skid_data_q, in_data;
	logic [ST_OUT:0]      vld_s;

	assign en       = ~vld_s[ST_OUT] | m_tready;
	assign s_tready = ~skid_v_q;
	assign acc      = s_tvalid & s_tready;
	assign in_v     = skid_v_q | acc;
	assign in_data  = skid_v_q ? skid_data_q : s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
			vld_s    <= '0;
		end else begin
			if (en) begin
				skid_v_q <= 1'b0;
				vld_s    <= {vld_s[ST_OUT-1:0], in_v};
			end else if (acc) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!en && acc) begin
			skid_data_q <= s_tdata;
		end
	end

	// payload registers
	logic signed [31:0]      diff_s1 [3];
	logic signed [31:0]      fold_s2 [3];
	logic [61:0]             sqr_s4 [3];
	logic [SQ_W-1:0]         sq_s5;
	logic [63:0]             sum_c;
	side_t                   side_s [ST_MAG:ST_SAT];
	logic [SQ_W-1:0]         dvs_s [ST_Q:ST_INV2-1];
	logic [SQ_W-1:0]         rem_s [ST_DIV0:ST_INV2-1];
	logic [INV2_W-1:0]       quo_s [ST_DIV0:ST_INV2];
	logic [INV2_W-1:0]       inv2_s [ST_P4:ST_G2];

	logic [63:0]             p4_ll_s48;
	logic [40:0]             p4_lh_s48;
	logic [17:0]             p4_hh_s48;
	logic [48:0]             inv4_s49;
	logic [63:0]             p6_ll_s50;
	logic [40:0]             p6_lh_s50;
	logic [48:0]             p6_hl_s50;
	logic [25:0]             p6_hh_s50;
	logic [56:0]             inv6_s51;
	logic [63:0]             p12_ll_s52, pe_l_s52;
	logic [56:0]             p12_lh_s52, pe_h_s52;
	logic [49:0]             p12_hh_s52;
	logic [60:0]             inv12_s53;
	logic [56:0]             a6_s53, a6_s54, a6_s55;
	logic [63:0]             pa_l_s54;
	logic [60:0]             pa_h_s54;
	logic [58:0]             a12_s55;
	logic [61:0]             t12_s56;
	logic [58:0]             t6_s56;
	logic signed [59:0]      e1_s56;
	logic signed [62:0]      g_s57;
	logic signed [60:0]      en0_s57;
	logic [61:0]             gmag_s58;
	logic [63:0]             pd_ll_s59;
	logic [40:0]             pd_lh_s59;
	logic [61:0]             pd_hl_s59;
	logic [38:0]             pd_hh_s59;
	logic [69:0]             da_s60;
	logic [62:0]             pf_l_s61 [3];
	logic [62:0]             pf_m_s61 [3];
	logic [36:0]             pf_h_s61 [3];
	logic [100:0]            prod_s62 [3];
	logic [OUT_W-1:0]        fmag_s63 [3];
	logic [OUT_W-1:0]        force_s64 [3];
	logic [OUT_W-1:0]        energy_s64;
	logic                    wl_s64, wc_s64;

	logic [81:0]             full4_c;
	logic [89:0]             full6_c;
	logic [113:0]            full12_c;
	logic [88:0]             fulle_c;
	logic [92:0]             fulla_c;
	logic [80:0]             sha_c;
	logic [102:0]            fulld_c;
	logic [100:0]            shf_c [3];
	logic [OUT_W-1:0]        lim_c [3];

	always_comb begin
		sum_c    = 64'(sqr_s4[0]) + 64'(sqr_s4[1]) + 64'(sqr_s4[2]);
		full4_c  = 82'(p4_ll_s48) + (82'(p4_lh_s48) << 33) + (82'(p4_hh_s48) << 64);
		full6_c  = 90'(p6_ll_s50) + (90'(p6_lh_s50) << 32) + (90'(p6_hl_s50) << 32)
			+ (90'(p6_hh_s50) << 64);
		full12_c = 114'(p12_ll_s52) + (114'(p12_lh_s52) << 33) + (114'(p12_hh_s52) << 64);
		fulle_c  = 89'(pe_l_s52) + (89'(pe_h_s52) << 32);
		fulla_c  = 93'(pa_l_s54) + (93'(pa_h_s54) << 32);
		sha_c    = fulla_c[92:12];
		fulld_c  = 103'(pd_ll_s59) + (103'(pd_lh_s59) << 32) + (103'(pd_hl_s59) << 32)
			+ (103'(pd_hh_s59) << 64);
		for (int k = 0; k < 3; k++) begin
			shf_c[k] = prod_s62[k] >> COORD_FRAC_BITS;
			lim_c[k] = (side_s[ST_F].gneg ^ side_s[ST_F].neg[k]) ? NEG_LIM : POS_LIM;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				diff_s1[k] <= $signed({1'b0, in_data[k*COORD_W +: COORD_W]})
					- $signed({1'b0, in_data[(k+3)*COORD_W +: COORD_W]});
				fold_s2[k] <= fold_fn(diff_s1[k], wrap_q, box_q);
				sqr_s4[k]  <= (62'(side_s[ST_MAG].mag[k]) * 62'(side_s[ST_MAG].mag[k]))
					>> SQ_SHIFT;
			end
			sq_s5 <= (sum_c > 64'(SQ_MAX)) ? SQ_MAX : sum_c[SQ_W-1:0];

			// inv2^2
			p4_ll_s48 <= 64'(quo_s[ST_INV2][31:0]) * 64'(quo_s[ST_INV2][31:0]);
			p4_lh_s48 <= 41'(quo_s[ST_INV2][31:0]) * 41'(quo_s[ST_INV2][40:32]);
			p4_hh_s48 <= 18'(quo_s[ST_INV2][40:32]) * 18'(quo_s[ST_INV2][40:32]);
			inv4_s49  <= full4_c[80:32];

			// inv4 * inv2
			p6_ll_s50 <= 64'(inv4_s49[31:0]) * 64'(inv2_s[ST_INV4][31:0]);
			p6_lh_s50 <= 41'(inv4_s49[31:0]) * 41'(inv2_s[ST_INV4][40:32]);
			p6_hl_s50 <= 49'(inv4_s49[48:32]) * 49'(inv2_s[ST_INV4][31:0]);
			p6_hh_s50 <= 26'(inv4_s49[48:32]) * 26'(inv2_s[ST_INV4][40:32]);
			inv6_s51  <= full6_c[88:32];

			// inv6^2 and e * inv6
			p12_ll_s52 <= 64'(inv6_s51[31:0]) * 64'(inv6_s51[31:0]);
			p12_lh_s52 <= 57'(inv6_s51[31:0]) * 57'(inv6_s51[56:32]);
			p12_hh_s52 <= 50'(inv6_s51[56:32]) * 50'(inv6_s51[56:32]);
			pe_l_s52   <= 64'(escale_q) * 64'(inv6_s51[31:0]);
			pe_h_s52   <= 57'(escale_q) * 57'(inv6_s51[56:32]);
			inv12_s53  <= full12_c[112:52];
			a6_s53     <= fulle_c[88:32];

			// e * inv12
			pa_l_s54 <= 64'(escale_q) * 64'(inv12_s53[31:0]);
			pa_h_s54 <= 61'(escale_q) * 61'(inv12_s53[60:32]);
			a6_s54   <= a6_s53;
			a12_s55  <= (sha_c > A12_CAP) ? A12_CAP[58:0] : sha_c[58:0];
			a6_s55   <= a6_s54;

			// energy and radial factor
			t12_s56 <= (62'(a12_s55) << 3) + (62'(a12_s55) << 2);
			t6_s56  <= (59'(a6_s55) << 2) + (59'(a6_s55) << 1);
			e1_s56  <= $signed({1'b0, a12_s55}) - $signed({3'b0, a6_s55});
			g_s57   <= $signed({1'b0, t12_s56}) - $signed({4'b0, t6_s56});
			en0_s57 <= 61'(e1_s56) - 61'(eshift_q);
			gmag_s58 <= g_s57[62] ? 62'(-g_s57) : 62'(g_s57);

			// |g| * inv2
			pd_ll_s59 <= 64'(gmag_s58[31:0]) * 64'(inv2_s[ST_G2][31:0]);
			pd_lh_s59 <= 41'(gmag_s58[31:0]) * 41'(inv2_s[ST_G2][40:32]);
			pd_hl_s59 <= 62'(gmag_s58[61:32]) * 62'(inv2_s[ST_G2][31:0]);
			pd_hh_s59 <= 39'(gmag_s58[61:32]) * 39'(inv2_s[ST_G2][40:32]);
			da_s60    <= fulld_c[101:32];

			// da * |d| per axis, shift, saturate, sign
			for (int k = 0; k < 3; k++) begin
				pf_l_s61[k] <= 63'(da_s60[31:0]) * 63'(side_s[ST_DA].mag[k]);
				pf_m_s61[k] <= 63'(da_s60[63:32]) * 63'(side_s[ST_DA].mag[k]);
				pf_h_s61[k] <= 37'(da_s60[69:64]) * 37'(side_s[ST_DA].mag[k]);
				prod_s62[k] <= 101'(pf_l_s61[k]) + (101'(pf_m_s61[k]) << 32)
					+ (101'(pf_h_s61[k]) << 64);
				fmag_s63[k] <= (shf_c[k] > 101'(lim_c[k])) ? lim_c[k] : shf_c[k][OUT_W-1:0];
				if (!side_s[ST_SAT].wc) begin
					force_s64[k] <= '0;
				end else if (side_s[ST_SAT].gneg ^ side_s[ST_SAT].neg[k]) begin
					force_s64[k] <= -fmag_s63[k];
				end else begin
					force_s64[k] <= fmag_s63[k];
				end
			end
			energy_s64 <= side_s[ST_SAT].wc ? side_s[ST_SAT].energy : '0;
			wl_s64     <= side_s[ST_SAT].wl;
			wc_s64     <= side_s[ST_SAT].wc;
		end
	end

	// per-pair side data
	for (genvar k = ST_MAG; k <= ST_SAT; k++) begin : g_side
		if (k == ST_MAG) begin : g_mag
			always_ff @(posedge clk) begin
				if (en) begin
					for (int a = 0; a < 3; a++) begin
						side_s[k].mag[a] <= fold_s2[a][31] ? 31'(-fold_s2[a])
							: fold_s2[a][COORD_W-1:0];
						side_s[k].neg[a] <= fold_s2[a][31];
					end
					side_s[k].wl     <= 1'b0;
					side_s[k].wc     <= 1'b0;
					side_s[k].gneg   <= 1'b0;
					side_s[k].energy <= '0;
				end
			end
		end else if (k == ST_Q) begin : g_flag
			always_ff @(posedge clk) begin
				if (en) begin
					side_s[k] <= {side_s[k-1].mag, side_s[k-1].neg, sq_s5 < lrad_q,
						sq_s5 < cut_q, side_s[k-1].gneg, side_s[k-1].energy};
				end
			end
		end else if (k == ST_G2) begin : g_en
			logic signed [OUT_W-1:0] en_sat;

			always_comb begin
				if (en0_s57 > EN_MAX) begin
					en_sat = EN_MAX[OUT_W-1:0];
				end else if (en0_s57 < EN_MIN) begin
					en_sat = EN_MIN[OUT_W-1:0];
				end else begin
					en_sat = en0_s57[OUT_W-1:0];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					side_s[k] <= {side_s[k-1].mag, side_s[k-1].neg, side_s[k-1].wl,
						side_s[k-1].wc, g_s57[62], en_sat};
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	// divisor floor
	always_ff @(posedge clk) begin
		if (en) begin
			dvs_s[ST_Q] <= (sq_s5 < SQ_FLOOR) ? SQ_FLOOR : sq_s5;
		end
	end

	// reciprocal 2^62 / q, one quotient bit per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [SQ_W-1:0]   rem_in;
		logic [INV2_W-1:0] quo_in;
		logic [SQ_W:0]     r2, rd;
		logic              ge;

		if (j == 0) begin : g_first
			assign rem_in = REM_INIT;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[ST_DIV0+j-1];
			assign quo_in = quo_s[ST_DIV0+j-1];
		end

		assign r2 = {rem_in, 1'b0};
		assign rd = r2 - {1'b0, dvs_s[ST_DIV0+j-1]};
		assign ge = ~rd[SQ_W];

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[ST_DIV0+j] <= {quo_in[INV2_W-2:0], ge};
			end
		end

		if (j < DIV_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[ST_DIV0+j] <= ge ? rd[SQ_W-1:0] : r2[SQ_W-1:0];
					dvs_s[ST_DIV0+j] <= dvs_s[ST_DIV0+j-1];
				end
			end
		end
	end

	// inv2 delay line
	for (genvar k = ST_P4; k <= ST_G2; k++) begin : g_inv2
		if (k == ST_P4) begin : g_head
			always_ff @(posedge clk) begin
				if (en) begin
					inv2_s[k] <= quo_s[ST_INV2];
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (en) begin
					inv2_s[k] <= inv2_s[k-1];
				end
			end
		end
	end

	assign m_tvalid = vld_s[ST_OUT];
	assign m_tdata  = {6'b0, wc_s64, wl_s64, energy_s64,
		force_s64[2], force_s64[1], force_s64[0]};

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the LJ pair force kernel: a bit-exact predictor
// runs on each accepted pair request, and every result on the master side is
// compared field by field with the oldest prediction. Directed corners come
// first. Random pairs follow under several register settings and idle mixes.
// ============================================================================
module tb;
	import ljpf_pkg::*;

	localparam int F        = COORD_FRAC_BITS_DEF;
	localparam int LATENCY  = 64;
	localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_LO = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_HI = 3'd7;
	localparam logic [63:0] M48       = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] POS_MAX48 = 64'h7FFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAG48 = 64'h8000_0000_0000;
	localparam logic [63:0] SQ_FLOOR  = 64'd1 << 22;
	localparam logic [63:0] A12_CAP   = 64'd1 << 58;
	localparam logic [30:0] ONE       = 31'd1 << F;

	typedef struct packed {
		logic        wc;
		logic        wl;
		logic [47:0] en;
		logic [47:0] fz;
		logic [47:0] fy;
		logic [47:0] fx;
	} pair_result_t;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_we = 0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 0;
	logic [M_TDATA_W-1:0]  m_tdata;

	logic [63:0] box_size, wrap_thr, list_sq, cut_sq, e_scale;
	longint      e_shift;

	pair_result_t expected_results[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_cut = 0;
	int idle_s = 0;
	int idle_r = 0;

	lj_pair_force_kernel DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) m_tready <= ($urandom_range(99) >= idle_r);

	function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		return (p[127:64] != 0) ? '1 : p[63:0];
	endfunction

	function automatic longint fold_axis(logic [30:0] a, logic [30:0] b);
		longint d;
		d = longint'({33'd0, a}) - longint'({33'd0, b});
		if (d > longint'(wrap_thr)) d -= longint'(box_size);
		else if (d < -longint'(wrap_thr)) d += longint'(box_size);
		return d;
	endfunction

	function automatic logic [47:0] axis_force(longint d, logic gneg, logic [63:0] gmag,
			logic [63:0] inv2);
		logic         dneg, neg;
		logic [127:0] dmag, da, p;
		logic [63:0]  limit, mag;
		dneg = d < 0;
		dmag = {64'd0, dneg ? -d : d};
		neg = gneg != dneg;
		da = ({64'd0, gmag} * {64'd0, inv2}) >> 32;
		p = da * dmag;
		p = p >> F;
		limit = neg ? NEG_MAG48 : POS_MAX48;
		mag = (p > {64'd0, limit}) ? limit : p[63:0];
		return neg ? 48'(-mag) : mag[47:0];
	endfunction

	function automatic pair_result_t predict_pair(logic [S_TDATA_W-1:0] data);
		pair_result_t r;
		longint       d[3];
		logic [63:0]  sq, mag, q, inv2, inv4, inv6, inv12, a12, a6, gmag;
		longint       en, g;
		logic         gneg;
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			d[k] = fold_axis(data[31*k +: 31], data[31*(k+3) +: 31]);
			mag = d[k] < 0 ? -d[k] : d[k];
			sq += (mag * mag) >> (2*F - 30);
		end
		if (sq > M48) sq = M48;
		r = '0;
		r.wl = sq < list_sq;
		r.wc = sq < cut_sq;
		if (r.wc) begin
			q = sq < SQ_FLOOR ? SQ_FLOOR : sq;
			inv2 = (64'd1 << 62) / q;
			inv4 = mul_shr(inv2, inv2, 32);
			inv6 = mul_shr(inv4, inv2, 32);
			inv12 = mul_shr(inv6, inv6, 52);
			a12 = mul_shr(e_scale, inv12, 12);
			a6 = mul_shr(e_scale, inv6, 32);
			if (a12 > A12_CAP) a12 = A12_CAP;
			en = longint'(a12) - longint'(a6) - e_shift;
			if (en > longint'(POS_MAX48)) en = longint'(POS_MAX48);
			if (en < -longint'(NEG_MAG48)) en = -longint'(NEG_MAG48);
			r.en = en[47:0];
			g = 12 * longint'(a12) - 6 * longint'(a6);
			gneg = g < 0;
			gmag = gneg ? -g : g;
			r.fx = axis_force(d[0], gneg, gmag, inv2);
			r.fy = axis_force(d[1], gneg, gmag, inv2);
			r.fz = axis_force(d[2], gneg, gmag, inv2);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH result %0d %s: got %h expected %h", n_checked, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		pair_result_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[$bits(pair_result_t)-1:0];
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(got.fx), 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (got.fx != want.fx) report_mismatch("force_x", 64'(got.fx), 64'(want.fx));
				if (got.fy != want.fy) report_mismatch("force_y", 64'(got.fy), 64'(want.fy));
				if (got.fz != want.fz) report_mismatch("force_z", 64'(got.fz), 64'(want.fz));
				if (got.en != want.en)
					report_mismatch("pair_energy", 64'(got.en), 64'(want.en));
				if (got.wl != want.wl)
					report_mismatch("within_list", 64'(got.wl), 64'(want.wl));
				if (got.wc != want.wc)
					report_mismatch("within_cutoff", 64'(got.wc), 64'(want.wc));
				if (want.wc) n_cut++;
			end
			n_checked++;
		end
	end

	task automatic send_pair(logic [30:0] fx, logic [30:0] fy, logic [30:0] fz,
			logic [30:0] sx, logic [30:0] sy, logic [30:0] sz);
		logic [S_TDATA_W-1:0] data;
		data = {6'd0, sz, sy, sx, fz, fy, fx};
		s_tvalid <= 1;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		expected_results.insert(expected_results.size(), predict_pair(data));
		n_sent++;
		if ($urandom_range(99) < idle_s) begin
			s_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_s);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [47:0] value);
		cfg_we    <= 1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			CFG_BOX_SIZE:       box_size = 64'(value[30:0]);
			CFG_WRAP_THRESHOLD: wrap_thr = 64'(value[30:0]);
			CFG_LIST_RADIUS_SQ: list_sq  = 64'(value);
			CFG_CUTOFF_SQ:      cut_sq   = 64'(value);
			CFG_ENERGY_SCALE:   e_scale  = 64'(value[31:0]);
			CFG_ENERGY_SHIFT:   e_shift  = longint'(signed'(value));
			default: ;
		endcase
	endtask

	task automatic set_config(logic [47:0] box, logic [47:0] thr, logic [47:0] lsq,
			logic [47:0] csq, logic [47:0] esc, logic [47:0] esh);
		drain();
		write_reg(CFG_BOX_SIZE, box);
		write_reg(CFG_WRAP_THRESHOLD, thr);
		write_reg(CFG_LIST_RADIUS_SQ, lsq);
		write_reg(CFG_CUTOFF_SQ, csq);
		write_reg(CFG_ENERGY_SCALE, esc);
		write_reg(CFG_ENERGY_SHIFT, esh);
		write_reg(CFG_UNUSED_LO, 48'({$urandom, $urandom}));
		write_reg(CFG_UNUSED_HI, 48'({$urandom, $urandom}));
		cfg_we <= 0;
	endtask

	task automatic set_box_config(logic [30:0] box);
		set_config({16'($urandom_range(65535)), 1'b0, box}, {17'h1FFFF, 1'b0, box[30:1]},
			48'd11_693_187_891, 48'd6_710_886_400,
			{16'hABCD, 32'd4 << 24}, -48'sd1_087_000);
	endtask

	task automatic test_directed();
		set_box_config(31'd10 << F);
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair('1, '1, '1, '1, '1, '1);
		send_pair('1, 0, '1, 0, '1, 0);
		send_pair(0, '1, 0, '1, 0, '1);
		send_pair(ONE, ONE, ONE, ONE + 31'd1000, ONE, ONE);
		send_pair(ONE, ONE, ONE, 31'd2 * ONE, ONE, ONE);
		send_pair(ONE, ONE, ONE, ONE, 31'd2 * ONE + (ONE >> 1), ONE);
		send_pair(ONE, ONE, ONE, ONE, ONE, 31'd2 * ONE + (ONE >> 1) + 31'd1);
		send_pair(31'd3 << F, ONE, ONE, 0, ONE, ONE);
		send_pair(31'd1 << (F-4), 0, 0, 0, 0, 0);
		send_pair(ONE >> 2, 0, 0, 31'd39 * (ONE >> 2), 0, 0);
		send_pair(31'd39 * (ONE >> 2), 0, 0, ONE >> 2, 0, 0);
		send_pair(0, ONE >> 1, 0, 0, 31'd9 * ONE + (ONE >> 1), 0);
		send_pair(ONE, ONE, ONE, ONE + (ONE >> 3), ONE + (ONE >> 3), ONE);
		set_config(48'h7FFF_FFFF, 48'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			48'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF);
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(ONE, 0, 0, ONE + 31'd5, 0, 0);
		send_pair('1, '1, '1, 0, 0, 0);
		send_pair(ONE, ONE, ONE, 31'd2 * ONE, 31'd2 * ONE, 31'd2 * ONE);
		set_config(0, 0, 48'hFFFF_FFFF_FFFF, 0, 48'd1 << 24, 48'h8000_0000_0000);
		send_pair(ONE, ONE, ONE, 31'd3 * ONE, ONE, ONE);
		send_pair('1, 0, 0, 0, '1, 0);
		set_config(48'd10 << F, 48'd5 << F, 0, 48'hFFFF_FFFF_FFFF, 48'd1 << 24,
			48'h8000_0000_0000);
		send_pair(ONE, ONE, ONE, 31'd3 * ONE, ONE, ONE);
		send_pair(ONE, ONE, ONE, ONE, ONE, ONE + (ONE >> 1));
	endtask

	task automatic send_random_pair(logic [30:0] box);
		logic [30:0] c[6];
		longint      o;
		for (int k = 0; k < 6; k++) c[k] = 31'($urandom);
		if ($urandom_range(99) < 75 && box > 31'd16) begin
			for (int k = 0; k < 3; k++) begin
				c[k] = 31'($urandom_range(box - 1));
				o = longint'($urandom_range(2 * 15 * (ONE / 4))) - 15 * (ONE / 4);
				o = longint'(c[k]) + o;
				if (o < 0) o += box;
				if (o >= box) o -= box;
				c[k+3] = o[30:0];
			end
		end
		send_pair(c[0], c[1], c[2], c[3], c[4], c[5]);
	endtask

	task automatic test_random(int count, int sender_idle, int receiver_idle,
			logic [30:0] box);
		drain();
		idle_s = sender_idle;
		idle_r = receiver_idle;
		set_box_config(box);
		repeat (count) send_random_pair(box);
		drain();
		set_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
		repeat (count / 4) send_random_pair(box);
	endtask

	initial begin
		box_size = 0; wrap_thr = 0; list_sq = 0; cut_sq = 0; e_scale = 0; e_shift = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(320, 31, 45, 31'd10 << F);
		test_random(320, 45, 31, 31'd6 << F);
		test_random(320, 0, 0, 31'h7FFF_FFFF);
		idle_s = 0;
		idle_r = 0;
		drain();
		$display("Sent %0d pair requests, checked %0d results, %0d inside the cutoff.",
			n_sent, n_checked, n_cut);
		$display("Covered corner coordinates, folds, close approach and register extremes.");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d results outstanding", expected_results.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ljpf_pkg.sv
rtl/core/lj_pair_force_kernel.sv
verif/tb.sv
